// ----- hw/rtl/tscp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tscp_pkg
// Shared constants, types and command/status bundles of the TDMA slot claim
// parser.
// ----------------------------------------------------------------------------
package tscp_pkg;

    localparam int MAX_SLOTS = 32;
    localparam int POS_W     = $clog2(MAX_SLOTS);
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
    localparam int REM_W     = CNT_W + 1;
    localparam int RND_W     = 16;
    localparam int BIT_W     = $clog2(RND_W);

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    // configuration register indexes
    localparam logic [1:0] REG_NODE_ID    = 2'd0;
    localparam logic [1:0] REG_INIT_CODE  = 2'd1;
    localparam logic [1:0] REG_REMAP_CODE = 2'd2;
    localparam logic [1:0] REG_DATA_CODE  = 2'd3;

    typedef enum logic [1:0] {
        KIND_UNKNOWN = 2'd0,
        KIND_INIT    = 2'd1,
        KIND_MAP     = 2'd2,
        KIND_DATA    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FINISH,
        ST_DIV,
        ST_READ,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic [7:0] node_id;
        logic [7:0] init_code;
        logic [7:0] remap_code;
        logic [7:0] data_code;
    } cfg_t;

    // controller -> datapath
    typedef struct packed {
        logic start;     // type byte taken
        logic scan;      // payload byte taken
        logic take_rnd;  // last byte taken, keep random value
        logic div_start;
        logic div_step;
        logic rd_en;
        logic load_fin;  // result without slot pick
        logic load_new;  // result with picked slot
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_div;
        logic div_done;
    } dp_status_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] header_type;
        logic [7:0] assigned_slot;
        logic       slot_reassigned;
        logic       no_free_slot;
        logic       slot_assigned_event;
    } result_t;

endpackage

// ----- hw/rtl/tscp_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tscp_cfg
// APB register file: node id and the three message type codes.
// ----------------------------------------------------------------------------
module tscp_cfg
    import tscp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] idx;
    logic       wr_en;
    logic [7:0] rd_byte;

    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_NODE_ID:    cfg_next.node_id    = pwdata[7:0];
                REG_INIT_CODE:  cfg_next.init_code  = pwdata[7:0];
                REG_REMAP_CODE: cfg_next.remap_code = pwdata[7:0];
                REG_DATA_CODE:  cfg_next.data_code  = pwdata[7:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_NODE_ID:    rd_byte = cfg_reg.node_id;
            REG_INIT_CODE:  rd_byte = cfg_reg.init_code;
            REG_REMAP_CODE: rd_byte = cfg_reg.remap_code;
            REG_DATA_CODE:  rd_byte = cfg_reg.data_code;
            default:        rd_byte = 8'd0;
        endcase
    end

    assign prdata = {{(CFG_DATA_W-8){1'b0}}, rd_byte};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.node_id    <= 8'd1;
            cfg_reg.init_code  <= 8'd1;
            cfg_reg.remap_code <= 8'd2;
            cfg_reg.data_code  <= 8'd3;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- hw/rtl/tscp_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tscp_ctrl
// Sequencer: byte intake, packet framing, slot pick and result handoff.
// ----------------------------------------------------------------------------
module tscp_ctrl
    import tscp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic       first_byte,
    input  logic       last_byte,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   open_reg;
    logic   open_next;
    logic   ovld_reg;
    logic   ovld_next;
    logic   accept;

    assign m_tvalid = ovld_reg;

    always_comb
    begin
        state_next = state_reg;
        open_next  = open_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        accept     = 1'b0;
        ovld_next  = (ovld_reg && m_tready) ? 1'b0 : ovld_reg;

        case (state_reg)
            ST_IDLE:
            begin
                // output slot must be free by the time a result could land
                s_tready = !ovld_reg || m_tready;
                accept   = s_tvalid && s_tready;
                if (accept)
                begin
                    cmd.start = first_byte;
                    cmd.scan  = !first_byte && open_reg;
                    if (first_byte || open_reg)
                    begin
                        open_next = !last_byte;
                        if (last_byte)
                        begin
                            cmd.take_rnd = 1'b1;
                            state_next   = ST_FINISH;
                        end
                    end
                end
            end
            ST_FINISH:
            begin
                if (status.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                begin
                    cmd.load_fin = 1'b1;
                    ovld_next    = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.load_new = 1'b1;
                ovld_next    = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            open_reg  <= 1'b0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            open_reg  <= open_next;
            ovld_reg  <= ovld_next;
        end
    end

endmodule

// ----- hw/rtl/tscp_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tscp_dpath
// Packet state, free position list, serial modulo unit and result register.
// ----------------------------------------------------------------------------
module tscp_dpath
    import tscp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  ctrl_cmd_t        cmd,
    input  logic [7:0]       rx_byte,
    input  logic [RND_W-1:0] random_value,
    output dp_status_t       status,
    output result_t          result
);

    logic [7:0]       own_reg,   own_next;
    logic [7:0]       ptype_reg, ptype_next;
    logic [CNT_W-1:0] pidx_reg,  pidx_next;
    logic             found_reg, found_next;
    logic [CNT_W-1:0] fcnt_reg,  fcnt_next;

    logic [RND_W-1:0] rnd_reg,   rnd_next;
    logic [REM_W-1:0] rem_reg,   rem_next;
    logic [BIT_W-1:0] bit_reg,   bit_next;

    result_t          res_reg,   res_next;

    logic [POS_W-1:0] mem [MAX_SLOTS];
    logic [POS_W-1:0] mem_q;
    logic             mem_we;

    kind_t            kind;
    logic             in_range;
    logic             room;
    logic [REM_W-1:0] rem_shift;
    logic [REM_W-1:0] divisor;

    // type decode, init has priority over slot map over data
    always_comb
    begin
        if (ptype_reg == cfg.init_code)
            kind = KIND_INIT;
        else if (ptype_reg == cfg.remap_code)
            kind = KIND_MAP;
        else if (ptype_reg == cfg.data_code)
            kind = KIND_DATA;
        else
            kind = KIND_UNKNOWN;
    end

    assign in_range = pidx_reg < CNT_W'(MAX_SLOTS);
    assign room     = fcnt_reg < CNT_W'(MAX_SLOTS);
    assign divisor  = REM_W'(fcnt_reg);
    assign rem_shift = {rem_reg[REM_W-2:0], rnd_reg[RND_W-1]};

    assign status.need_div = (kind == KIND_MAP) && !found_reg && (fcnt_reg != '0);
    assign status.div_done = bit_reg == BIT_W'(RND_W - 1);

    always_comb
    begin
        own_next   = own_reg;
        ptype_next = ptype_reg;
        pidx_next  = pidx_reg;
        found_next = found_reg;
        fcnt_next  = fcnt_reg;
        rnd_next   = rnd_reg;
        rem_next   = rem_reg;
        bit_next   = bit_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;

        if (cmd.start)
        begin
            ptype_next = rx_byte;
            pidx_next  = '0;
            found_next = 1'b0;
            fcnt_next  = '0;
        end
        else if (cmd.scan && in_range)
        begin
            pidx_next = pidx_reg + CNT_W'(1);
            if (!found_reg)
            begin
                // id match wins over the free test
                if (rx_byte == cfg.node_id)
                begin
                    found_next = 1'b1;
                end
                else if (rx_byte == 8'h00 && 8'(pidx_reg) != own_reg && room)
                begin
                    mem_we    = 1'b1;
                    fcnt_next = fcnt_reg + CNT_W'(1);
                end
            end
        end

        if (cmd.take_rnd)
        begin
            rnd_next = random_value;
        end

        // restoring remainder, one dividend bit per cycle
        if (cmd.div_start)
        begin
            rem_next = '0;
            bit_next = '0;
        end
        else if (cmd.div_step)
        begin
            rem_next = (rem_shift >= divisor) ? rem_shift - divisor : rem_shift;
            rnd_next = {rnd_reg[RND_W-2:0], 1'b0};
            bit_next = bit_reg + BIT_W'(1);
        end

        if (cmd.load_fin)
        begin
            if (kind == KIND_INIT)
            begin
                own_next = cfg.node_id - 8'd1;
            end
            res_next.kind                = kind;
            res_next.header_type         = ptype_reg;
            res_next.assigned_slot       = (kind == KIND_INIT) ? cfg.node_id - 8'd1 : own_reg;
            res_next.slot_reassigned     = 1'b0;
            res_next.no_free_slot        = (kind == KIND_MAP) && !found_reg;
            res_next.slot_assigned_event = kind != KIND_UNKNOWN;
        end
        else if (cmd.load_new)
        begin
            own_next                     = 8'(mem_q);
            res_next.kind                = KIND_MAP;
            res_next.header_type         = ptype_reg;
            res_next.assigned_slot       = 8'(mem_q);
            res_next.slot_reassigned     = 1'b1;
            res_next.no_free_slot        = 1'b0;
            res_next.slot_assigned_event = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_reg   <= '0;
            ptype_reg <= '0;
            pidx_reg  <= '0;
            found_reg <= 1'b0;
            fcnt_reg  <= '0;
        end
        else
        begin
            own_reg   <= own_next;
            ptype_reg <= ptype_next;
            pidx_reg  <= pidx_next;
            found_reg <= found_next;
            fcnt_reg  <= fcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rnd_reg <= rnd_next;
        rem_reg <= rem_next;
        bit_reg <= bit_next;
        res_reg <= res_next;
    end

    // free position list
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[fcnt_reg[POS_W-1:0]] <= pidx_reg[POS_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            mem_q <= mem[rem_reg[POS_W-1:0]];
        end
    end

    assign result = res_reg;

endmodule

// ----- hw/rtl/tdma_slot_claim_parser_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdma_slot_claim_parser_unit
// TDMA slot claim parser: reads packet bytes and maintains this node's slot.
// ----------------------------------------------------------------------------
// Input stream: one packet byte per transfer. tuser marks the type byte that
// opens a packet, tlast its final byte, tdata carries the byte and a random
// value that is used only with the last byte. Output stream: one transfer
// per finished packet with the packet kind on tuser and the slot result on
// tdata. Registers (node id, three type codes) sit on the APB port and are
// to be written only while the unit is idle; the user must ensure this, as
// the unit does not enforce it. Timing: bytes that do not end a packet are
// taken in idle. A final byte moves the sequencer to a finish state which,
// with no slot to pick, loads the result register and raises m_tvalid; the
// input reopens back in idle. When a slot-map packet must pick a new slot,
// the finish state starts a restoring remainder unit that works out
// random_value modulo the free count one bit per cycle; a read of the free
// position memory and a load state follow. Input is not taken meanwhile.
// A finished result waits in the output register; while it waits and
// m_tready is low no byte is taken, so a stalled receiver stalls the input.
// Reset: own slot 0, no packet open, registers at their defaults; the free
// position memory needs no clearing since only filled entries are read.
// ----------------------------------------------------------------------------
module tdma_slot_claim_parser_unit
    import tscp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    // byte input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // rx_byte[7:0], random_value[23:8]
    input  logic                  s_tuser,   // first_byte
    input  logic                  s_tlast,   // last_byte
    // result output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // header_type[7:0], assigned_slot[15:8],
                                             // slot_reassigned[16], no_free_slot[17],
                                             // slot_assigned_event[18], zero[23:19]
    output logic [1:0]            m_tuser    // packet_kind
);

    cfg_t       cfg;
    ctrl_cmd_t  cmd;
    dp_status_t status;
    result_t    result;

    tscp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer
    tscp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .first_byte (s_tuser),
        .last_byte  (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .status     (status),
        .cmd        (cmd)
    );

    // packet state, free list, modulo unit, result register
    tscp_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd          (cmd),
        .rx_byte      (s_tdata[7:0]),
        .random_value (s_tdata[23:8]),
        .status       (status),
        .result       (result)
    );

    assign m_tuser = result.kind;
    assign m_tdata = {5'd0,
                      result.slot_assigned_event,
                      result.no_free_slot,
                      result.slot_reassigned,
                      result.assigned_slot,
                      result.header_type};

endmodule
